// ----- rtl/nnp_pkg.sv -----
package nnp_pkg;

    // Score bytes that the parser recognizes.
    localparam logic [7:0] CH_SHARP = 8'h23;  // '#'
    localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
    localparam logic [7:0] CH_DASH  = 8'h2D;  // '-'
    localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
    localparam logic [7:0] CH_HIGH  = 8'h48;  // 'H'
    localparam logic [7:0] CH_LOW   = 8'h4C;  // 'L'
    localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
    localparam logic [7:0] CH_EQUAL = 8'h3D;  // '='
    localparam logic [7:0] CH_WHOLE = 8'h4F;  // 'O'

    // Digits '0' to '7' share these upper five bits.
    localparam logic [4:0] DIGIT_HI = 5'b00110;

    localparam logic [7:0] SEMITONES = 8'd12;

    // Configuration register indexes.
    localparam logic [1:0] REG_OCTAVE_BASE = 2'd0;
    localparam logic [1:0] REG_KEY_OFFSET  = 2'd1;
    localparam logic [1:0] REG_QUARTER_MS  = 2'd2;

    localparam logic [2:0]  OCTAVE_BASE_RST = 3'd2;
    localparam logic [3:0]  KEY_OFFSET_RST  = 4'd0;
    localparam logic [15:0] QUARTER_MS_RST  = 16'd952;

    // Note phases of the back end.
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_NOTE  = 3'd1;
    localparam logic [2:0] PH_SHARP = 3'd2;
    localparam logic [2:0] PH_DOT   = 3'd3;
    localparam logic [2:0] PH_HOLD  = 3'd4;

    // Result buffer; a power of two of at least two entries.
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 3;

    // One classified score column.
    typedef struct packed {
        logic        digit;
        logic        sharp;
        logic        dot;
        logic        dash;
        logic        last;
        logic [7:0]  tone;
        logic [15:0] beat;
    } t_item;

    // One emitted note.
    typedef struct packed {
        logic [7:0]  tone;
        logic [15:0] beat;
        logic [7:0]  holds;
        logic        last;
    } t_result;

    // Semitone step of a scale degree; degree zero is a rest.
    function automatic logic [3:0] step_of(input logic [2:0] degree);
        logic [3:0] s;
        case (degree)
            3'd0:    s = 4'd0;
            3'd1:    s = 4'd1;
            3'd2:    s = 4'd3;
            3'd3:    s = 4'd5;
            3'd4:    s = 4'd6;
            3'd5:    s = 4'd8;
            3'd6:    s = 4'd10;
            default: s = 4'd12;
        endcase
        return s;
    endfunction

    // Octave mark plus one, so that the low mark maps to zero.
    function automatic logic [2:0] mark_of(input logic [7:0] c);
        logic [2:0] m;
        case (c)
            CH_STAR: m = 3'd3;
            CH_DASH: m = 3'd2;
            CH_DOT:  m = 3'd1;
            CH_HIGH: m = 3'd4;
            CH_LOW:  m = 3'd0;
            default: m = 3'd2;
        endcase
        return m;
    endfunction

    // Duration mark as a right shift of the quarter length.
    function automatic logic [1:0] shift_of(input logic [7:0] c);
        logic [1:0] s;
        case (c)
            CH_SPACE: s = 2'd0;
            CH_DASH:  s = 2'd1;
            CH_EQUAL: s = 2'd2;
            CH_WHOLE: s = 2'd3;
            default:  s = 2'd2;
        endcase
        return s;
    endfunction

endpackage

// ----- rtl/nnp_front.sv -----
module nnp_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_valid,
    input  logic [7:0]           i_melody_char,
    input  logic [7:0]           i_octave_char,
    input  logic [7:0]           i_duration_char,
    input  logic                 i_end_of_tune,
    input  logic                 i_full,
    output logic                 o_stall,
    output logic                 o_push,
    output nnp_pkg::t_item       o_item,
    output logic [3:0]           o_key_offset
);
    import nnp_pkg::*;

    logic [2:0]  r_octave_base;
    logic [3:0]  r_key_offset;
    logic [15:0] r_quarter_ms;

    logic [3:0] step;
    logic [3:0] oct_sum;
    logic [7:0] tone_raw;

    // Configuration registers; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octave_base <= OCTAVE_BASE_RST;
            r_key_offset  <= KEY_OFFSET_RST;
            r_quarter_ms  <= QUARTER_MS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_OCTAVE_BASE: r_octave_base <= i_cfg_data[2:0];
                REG_KEY_OFFSET:  r_key_offset  <= i_cfg_data[3:0];
                REG_QUARTER_MS:  r_quarter_ms  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Starting tone of a note: step plus twelve times the octave term, less twelve.
    always_comb begin
        step     = step_of(i_melody_char[2:0]);
        oct_sum  = {1'b0, r_octave_base} + {1'b0, mark_of(i_octave_char)};
        tone_raw = {4'b0000, step} + {1'b0, oct_sum, 3'b000}
                 + {2'b00, oct_sum, 2'b00} - SEMITONES;
    end

    // Classify the column for the back end.
    always_comb begin
        o_item.digit = (i_melody_char[7:3] == DIGIT_HI);
        o_item.sharp = (i_melody_char == CH_SHARP);
        o_item.dot   = (i_melody_char == CH_DOT);
        o_item.dash  = (i_melody_char == CH_DASH);
        o_item.last  = i_end_of_tune;
        o_item.tone  = (step != 4'd0) ? tone_raw : 8'd0;
        o_item.beat  = r_quarter_ms >> shift_of(i_duration_char);
    end

    assign o_push       = i_valid & ~i_full;
    assign o_stall      = i_full;
    assign o_key_offset = r_key_offset;

endmodule

// ----- rtl/nnp_queue.sv -----
module nnp_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  nnp_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output nnp_pkg::t_item o_item
);
    import nnp_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count exceeds depth");
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_rd_ptr == r_wr_ptr))
        else $error("empty queue with unequal pointers");
`endif

endmodule

// ----- rtl/nnp_back.sv -----
module nnp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [3:0]     i_key_offset,
    input  logic           i_valid,
    input  nnp_pkg::t_item i_item,
    output logic           o_pop,
    input  logic           i_stall,
    output logic           o_valid,
    output logic [7:0]     o_tone_index,
    output logic [15:0]    o_beat_ms,
    output logic [7:0]     o_hold_count,
    output logic           o_final_note
);
    import nnp_pkg::*;

    logic [2:0]  r_phase;
    logic [7:0]  r_tone;
    logic [15:0] r_beat;
    logic [7:0]  r_holds;

    t_result          r_out [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_wr_ptr;
    logic [OUT_PTR_W-1:0] r_rd_ptr;
    logic [OUT_CNT_W-1:0] r_out_count;

    logic [2:0]  n_phase;
    logic [7:0]  n_tone;
    logic [15:0] n_beat;
    logic [7:0]  n_holds;
    logic [16:0] dotted;
    logic        used;
    logic        emit0;
    logic        emit1;
    t_result     res0;
    t_result     res1;
    t_result     first;
    logic        out_pop;
    logic [1:0]  push_cnt;

    // Key offset applies to every sounding tone.
    function automatic logic [7:0] keyed(input logic [7:0] t, input logic [3:0] k);
        return (t != 8'd0) ? t + {4'b0000, k} : t;
    endfunction

    // Take a column only when two result slots are free.
    assign o_pop   = i_valid && (r_out_count <= OUT_CNT_W'(OUT_DEPTH - 2));
    assign out_pop = o_valid & ~i_stall;

    // Phase machine for one column.
    always_comb begin
        n_phase = r_phase;
        n_tone  = r_tone;
        n_beat  = r_beat;
        n_holds = r_holds;
        used    = 1'b0;
        emit0   = 1'b0;
        dotted  = {1'b0, r_beat} + {2'b00, r_beat[15:1]};
        res0    = '{tone: keyed(r_tone, i_key_offset), beat: r_beat,
                    holds: r_holds, last: 1'b0};
        if (r_phase != PH_IDLE) begin
            if (i_item.sharp && r_phase == PH_NOTE) begin
                n_tone  = r_tone + 1'b1;
                n_phase = PH_SHARP;
                used    = 1'b1;
            end else if (i_item.dot && (r_phase inside {PH_NOTE, PH_SHARP})) begin
                n_beat  = dotted[16] ? 16'hFFFF : dotted[15:0];
                n_phase = PH_DOT;
                used    = 1'b1;
            end else if (i_item.dash) begin
                n_holds = (r_holds != 8'hFF) ? r_holds + 1'b1 : r_holds;
                n_phase = PH_HOLD;
                used    = 1'b1;
            end else begin
                emit0   = 1'b1;
                n_phase = PH_IDLE;
            end
        end
        if (!used && i_item.digit) begin
            n_tone  = i_item.tone;
            n_beat  = i_item.beat;
            n_holds = 8'd0;
            n_phase = PH_NOTE;
        end
        emit1 = i_item.last && (n_phase != PH_IDLE);
        res1  = '{tone: keyed(n_tone, i_key_offset), beat: n_beat,
                  holds: n_holds, last: 1'b1};
        if (i_item.last) begin
            n_phase = PH_IDLE;
        end
        first    = emit0 ? res0 : res1;
        push_cnt = o_pop ? {1'b0, emit0} + {1'b0, emit1} : 2'd0;
    end

    // Pending note state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tone  <= '0;
            r_beat  <= '0;
            r_holds <= '0;
        end else if (o_pop) begin
            r_phase <= n_phase;
            r_tone  <= n_tone;
            r_beat  <= n_beat;
            r_holds <= n_holds;
        end
    end

    // Result buffer storage; up to two results enter per cycle.
    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_out[r_wr_ptr] <= first;
        end
        if (push_cnt == 2'd2) begin
            r_out[r_wr_ptr + 1'b1] <= res1;
        end
    end

    // Result buffer pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_out_count <= '0;
        end else begin
            r_wr_ptr    <= r_wr_ptr + OUT_PTR_W'(push_cnt);
            r_rd_ptr    <= r_rd_ptr + OUT_PTR_W'(out_pop);
            r_out_count <= r_out_count + OUT_CNT_W'(push_cnt) - OUT_CNT_W'(out_pop);
        end
    end

    assign o_valid      = (r_out_count != '0);
    assign o_tone_index = r_out[r_rd_ptr].tone;
    assign o_beat_ms    = r_out[r_rd_ptr].beat;
    assign o_hold_count = r_out[r_rd_ptr].holds;
    assign o_final_note = r_out[r_rd_ptr].last;

`ifndef SYNTHESIS
    a_out_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_count <= OUT_CNT_W'(OUT_DEPTH))
        else $error("result buffer overflow");
    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_item.last) |=> (r_phase == PH_IDLE))
        else $error("phase not idle after end of tune");
`endif

endmodule

// ----- rtl/numbered_notation_note_parser.sv -----
// An accepted column enters the column queue; the back end pops it and writes its
// note words into the result buffer. Throughput: one column per cycle while the
// queue is not full; the back end takes a column only while the four-entry result
// buffer has two free slots; the output moves one word per cycle unless stalled.
// Reset (synchronous, active low) empties both queues, sets the phase to idle and
// loads octave_base 2, key_offset 0 and quarter_ms 952.
module numbered_notation_note_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_melody_char,
    input  logic [7:0]  i_octave_char,
    input  logic [7:0]  i_duration_char,
    input  logic        i_end_of_tune,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_tone_index,
    output logic [15:0] o_beat_ms,
    output logic [7:0]  o_hold_count,
    output logic        o_final_note
);
    import nnp_pkg::*;

    logic       push;
    logic       full;
    logic       q_valid;
    logic       pop;
    logic [3:0] key_offset;
    t_item      front_item;
    t_item      head_item;

    // Column classification and configuration.
    nnp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .i_melody_char   (i_melody_char),
        .i_octave_char   (i_octave_char),
        .i_duration_char (i_duration_char),
        .i_end_of_tune   (i_end_of_tune),
        .i_full          (full),
        .o_stall         (o_stall),
        .o_push          (push),
        .o_item          (front_item),
        .o_key_offset    (key_offset)
    );

    // Column queue between the two halves.
    nnp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_item  (head_item)
    );

    // Note phase machine and result buffer.
    nnp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key_offset (key_offset),
        .i_valid      (q_valid),
        .i_item       (head_item),
        .o_pop        (pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_tone_index (o_tone_index),
        .o_beat_ms    (o_beat_ms),
        .o_hold_count (o_hold_count),
        .o_final_note (o_final_note)
    );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import nnp_pkg::*;

    // Index with no register behind it; writes to it must change nothing.
    localparam logic [1:0] REG_SPARE     = 2'd3;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_SEVEN      = 8'h37;
    localparam logic [7:0] CH_BAR        = 8'h7C;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         HOLD_RUN      = 260;
    localparam int         STRETCH_ITEMS = 12;

    // Tracks the parser state and keeps the note words that are still due.
    class note_tracker;
        logic [2:0]  octave_base;
        logic [3:0]  key_offset;
        logic [15:0] quarter_ms;
        logic [2:0]  phase;
        logic [7:0]  tone;
        logic [15:0] beat;
        logic [7:0]  holds;
        t_result     due_notes[$];
        int          mismatches;

        function new();
            octave_base = OCTAVE_BASE_RST;
            key_offset  = KEY_OFFSET_RST;
            quarter_ms  = QUARTER_MS_RST;
            phase       = PH_IDLE;
            tone        = 8'd0;
            beat        = 16'd0;
            holds       = 8'd0;
            mismatches  = 0;
        endfunction

        function void write_reg(input logic [1:0] index, input logic [15:0] data);
            case (index)
                REG_OCTAVE_BASE: octave_base = data[2:0];
                REG_KEY_OFFSET:  key_offset = data[3:0];
                REG_QUARTER_MS:  quarter_ms = data;
                default: ;
            endcase
        endfunction

        function int outstanding();
            return due_notes.size();
        endfunction

        // The key offset applies at emission and only to a nonzero tone.
        function void push_note(input logic last);
            t_result note;
            note.tone  = (tone != 8'd0) ? 8'(tone + key_offset) : tone;
            note.beat  = beat;
            note.holds = holds;
            note.last  = last;
            due_notes.push_back(note);
        endfunction

        function void start_note(input logic [7:0] m, input logic [7:0] oc,
                                  input logic [7:0] du);
            int step;
            int lift;
            int divisor;
            case (m[2:0])
                3'd0:    step = 0;
                3'd1:    step = 1;
                3'd2:    step = 3;
                3'd3:    step = 5;
                3'd4:    step = 6;
                3'd5:    step = 8;
                3'd6:    step = 10;
                default: step = 12;
            endcase
            // Octave mark raised by one so that the low mark is zero.
            case (oc)
                CH_STAR: lift = 3;
                CH_DASH: lift = 2;
                CH_DOT:  lift = 1;
                CH_HIGH: lift = 4;
                CH_LOW:  lift = 0;
                default: lift = 2;
            endcase
            case (du)
                CH_SPACE: divisor = 1;
                CH_DASH:  divisor = 2;
                CH_EQUAL: divisor = 4;
                CH_WHOLE: divisor = 8;
                default:  divisor = 4;
            endcase
            // A low mark at octave base zero goes negative and wraps.
            if (step != 0) begin
                tone = 8'(step + int'(SEMITONES) * (int'(octave_base) + lift - 1));
            end else begin
                tone = 8'd0;
            end
            beat  = 16'(int'(quarter_ms) / divisor);
            holds = 8'd0;
            phase = PH_NOTE;
        endfunction

        // Called once per accepted score column.
        function void take_column(input logic [7:0] m, input logic [7:0] oc,
                                  input logic [7:0] du, input logic eot);
            logic used;
            int   dotted;
            used = 1'b0;
            if (phase != PH_IDLE) begin
                if (m == CH_SHARP && phase == PH_NOTE) begin
                    tone  = tone + 8'd1;
                    phase = PH_SHARP;
                    used  = 1'b1;
                end else if (m == CH_DOT && (phase == PH_NOTE || phase == PH_SHARP)) begin
                    dotted = int'(beat) + int'(beat >> 1);
                    beat   = (dotted > 65535) ? 16'hFFFF : 16'(dotted);
                    phase  = PH_DOT;
                    used   = 1'b1;
                end else if (m == CH_DASH) begin
                    if (holds != 8'hFF) begin
                        holds = holds + 8'd1;
                    end
                    phase = PH_HOLD;
                    used  = 1'b1;
                end else begin
                    push_note(1'b0);
                    phase = PH_IDLE;
                end
            end
            if (!used && m >= CH_ZERO && m <= CH_SEVEN) begin
                start_note(m, oc, du);
            end
            if (eot) begin
                if (phase != PH_IDLE) begin
                    push_note(1'b1);
                end
                phase = PH_IDLE;
            end
        endfunction

        function void check_note(input t_result got);
            t_result want;
            if (due_notes.size() == 0) begin
                $error("note word with none due: tone_index %0d beat_ms %0d hold_count %0d",
                       got.tone, got.beat, got.holds);
                mismatches++;
            end else begin
                want = due_notes.pop_front();
                if (got.tone != want.tone) begin
                    $error("tone_index: expected %0d, actual %0d", want.tone, got.tone);
                    mismatches++;
                end
                if (got.beat != want.beat) begin
                    $error("beat_ms: expected %0d, actual %0d", want.beat, got.beat);
                    mismatches++;
                end
                if (got.holds != want.holds) begin
                    $error("hold_count: expected %0d, actual %0d", want.holds, got.holds);
                    mismatches++;
                end
                if (got.last != want.last) begin
                    $error("final_note: expected %0d, actual %0d", want.last, got.last);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_melody_char;
    logic [7:0]  i_octave_char;
    logic [7:0]  i_duration_char;
    logic        i_end_of_tune;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_tone_index;
    logic [15:0] o_beat_ms;
    logic [7:0]  o_hold_count;
    logic        o_final_note;

    note_tracker tracker = new();
    t_result     seen_note;
    bit          tx_gaps = 1'b1;
    bit          rx_gaps = 1'b1;
    int          stall_left = 0;
    int          cycles = 0;

    numbered_notation_note_parser DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_melody_char   (i_melody_char),
        .i_octave_char   (i_octave_char),
        .i_duration_char (i_duration_char),
        .i_end_of_tune   (i_end_of_tune),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_tone_index    (o_tone_index),
        .o_beat_ms       (o_beat_ms),
        .o_hold_count    (o_hold_count),
        .o_final_note    (o_final_note)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver back-pressure comes in bursts of random length.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if (rx_gaps && i_rst_n && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 11);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Every note word taken from the output is checked against the oldest one due.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            seen_note.tone  = o_tone_index;
            seen_note.beat  = o_beat_ms;
            seen_note.holds = o_hold_count;
            seen_note.last  = o_final_note;
            tracker.check_note(seen_note);
        end
    end

    // Guard against a hung handshake.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_octave_mark();
        logic [7:0] c;
        case ($urandom_range(0, 6))
            0:       c = CH_STAR;
            1:       c = CH_DASH;
            2:       c = CH_DOT;
            3:       c = CH_HIGH;
            4:       c = CH_LOW;
            default: c = any_byte();
        endcase
        return c;
    endfunction

    function automatic logic [7:0] pick_duration_mark();
        logic [7:0] c;
        case ($urandom_range(0, 5))
            0:       c = CH_SPACE;
            1:       c = CH_DASH;
            2:       c = CH_EQUAL;
            3:       c = CH_WHOLE;
            default: c = any_byte();
        endcase
        return c;
    endfunction

    // Stray melody bytes: marks out of place, separators, non-scale digits, anything.
    function automatic logic [7:0] pick_noise_byte();
        logic [7:0] c;
        case ($urandom_range(0, 7))
            0:       c = CH_SHARP;
            1:       c = CH_DOT;
            2:       c = CH_DASH;
            3:       c = CH_SPACE;
            4:       c = CH_BAR;
            5:       c = "8";
            6:       c = "9";
            default: c = any_byte();
        endcase
        return c;
    endfunction

    // Offer one column, sometimes after a random gap, and hold it until it is taken.
    task automatic send_column(input logic [7:0] m, input logic [7:0] oc,
                               input logic [7:0] du, input logic eot);
        int gap;
        if (tx_gaps && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_melody_char   <= m;
        i_octave_char   <= oc;
        i_duration_char <= du;
        i_end_of_tune   <= eot;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        tracker.take_column(m, oc, du, eot);
    endtask

    // Stop sending and let every due note word drain, then let the pipe settle.
    task automatic wait_for_notes();
        i_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Leaves the write enable high so back-to-back writes need one assignment each.
    task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        tracker.write_reg(index, data);
    endtask

    // Unused upper data bits carry random values; only the register width counts.
    task automatic configure(input logic [2:0] base, input logic [3:0] key,
                             input logic [15:0] quarter);
        logic [15:0] data;
        data = 16'($urandom_range(0, 65535));
        data[2:0] = base;
        write_reg(REG_OCTAVE_BASE, data);
        data = 16'($urandom_range(0, 65535));
        data[3:0] = key;
        write_reg(REG_KEY_OFFSET, data);
        write_reg(REG_QUARTER_MS, quarter);
        write_reg(REG_SPARE, 16'($urandom_range(0, 65535)));
        i_cfg_we <= 1'b0;
    endtask

    // Mostly well-formed notes with random marks, mixed with stray columns.
    task automatic random_stretch(input int n_items);
        int   sent;
        int   cols;
        int   k;
        int   holds_n;
        logic sharp_on;
        logic dot_on;
        logic close;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) < 7) begin
                sharp_on = ($urandom_range(0, 2) == 0);
                dot_on   = ($urandom_range(0, 2) == 0);
                holds_n  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8)
                                                       : $urandom_range(0, 2);
                close    = ($urandom_range(0, 9) == 0);
                cols     = 1 + int'(sharp_on) + int'(dot_on) + holds_n;
                k        = 1;
                send_column(CH_ZERO | 8'($urandom_range(0, 7)), pick_octave_mark(),
                            pick_duration_mark(), close && k == cols);
                if (sharp_on) begin
                    k++;
                    send_column(CH_SHARP, any_byte(), any_byte(), close && k == cols);
                end
                if (dot_on) begin
                    k++;
                    send_column(CH_DOT, any_byte(), any_byte(), close && k == cols);
                end
                repeat (holds_n) begin
                    k++;
                    send_column(CH_DASH, any_byte(), any_byte(), close && k == cols);
                end
                sent += cols;
            end else begin
                send_column(pick_noise_byte(), any_byte(), any_byte(),
                            $urandom_range(0, 7) == 0);
            end
        end
        // An end column leaves nothing pending before the next register write.
        send_column(any_byte(), any_byte(), any_byte(), 1'b1);
    endtask

    initial begin
        logic [2:0]  base;
        logic [3:0]  key;
        logic [15:0] quarter;

        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= REG_OCTAVE_BASE;
        i_cfg_data      <= 16'd0;
        i_valid         <= 1'b0;
        i_melody_char   <= 8'd0;
        i_octave_char   <= 8'd0;
        i_duration_char <= 8'd0;
        i_end_of_tune   <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed columns at reset settings.
        send_column("1", CH_STAR, CH_SPACE, 1'b0);
        send_column(CH_SHARP, 8'h00, 8'hFF, 1'b0);
        send_column(CH_DOT, 8'hFF, 8'h00, 1'b0);
        send_column(CH_DASH, CH_LOW, CH_WHOLE, 1'b0);
        send_column(CH_DASH, 8'h55, 8'hAA, 1'b0);
        // A new note emits the old one; a sharp then lifts the rest to tone one.
        send_column("0", CH_LOW, CH_WHOLE, 1'b0);
        send_column(CH_SHARP, 8'hAA, 8'h55, 1'b0);
        send_column(CH_SPACE, 8'h00, 8'h00, 1'b0);
        // Continuation with nothing pending is dropped.
        send_column(CH_SHARP, 8'h00, 8'h00, 1'b0);
        // A sharp after the dot ends the note.
        send_column("7", CH_HIGH, CH_EQUAL, 1'b0);
        send_column(CH_DOT, 8'h00, 8'h00, 1'b0);
        send_column(CH_SHARP, 8'h00, 8'h00, 1'b0);
        // A dot after a hold ends the note.
        send_column("3", CH_DOT, CH_DASH, 1'b0);
        send_column(CH_DASH, 8'h00, 8'h00, 1'b0);
        send_column(CH_DOT, 8'h00, 8'h00, 1'b0);
        send_column("5", 8'h00, 8'hFF, 1'b0);
        send_column("9", 8'h00, 8'h00, 1'b0);
        send_column("2", CH_DASH, "Z", 1'b1);
        // A note begun on the end column is emitted at once as the final one.
        send_column("4", CH_STAR, CH_WHOLE, 1'b1);
        send_column(CH_DASH, 8'hFF, 8'hFF, 1'b1);
        send_column("6", CH_LOW, CH_SPACE, 1'b0);
        send_column(CH_DASH, 8'h00, 8'h00, 1'b1);
        send_column(8'h00, 8'hFF, 8'h00, 1'b0);
        send_column(8'hFF, 8'h00, 8'hFF, 1'b0);
        send_column("1", CH_HIGH, CH_DASH, 1'b1);

        // A hold run long enough to saturate the counter.
        send_column("5", CH_DOT, CH_EQUAL, 1'b0);
        repeat (HOLD_RUN) send_column(CH_DASH, any_byte(), any_byte(), 1'b0);
        send_column(CH_BAR, 8'h00, 8'h00, 1'b1);

        // Register settings: four directed ones first, the extremes among them, then random ones.
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin base = 3'd0; key = 4'd0;  quarter = 16'd0;     end
                1: begin base = 3'd7; key = 4'd15; quarter = 16'hFFFF;  end
                2: begin base = 3'd4; key = 4'd12; quarter = 16'd43690; end
                3: begin base = 3'd0; key = 4'd12; quarter = 16'd1;     end
                default: begin
                    base    = 3'($urandom_range(0, 7));
                    key     = 4'($urandom_range(0, 15));
                    quarter = 16'($urandom_range(0, 65535));
                end
            endcase
            wait_for_notes();
            configure(base, key, quarter);
            tx_gaps = (p != 3);
            rx_gaps = (p != 2);
            random_stretch(STRETCH_ITEMS);
        end

        // Last part runs at full rate on both sides.
        wait_for_notes();
        configure(OCTAVE_BASE_RST, 4'($urandom_range(0, 15)), QUARTER_MS_RST);
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        random_stretch(STRETCH_ITEMS);

        wait_for_notes();
        if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
